// ===== hw/rtl/tme_pkg.sv =====
// ----------------------------------------------------------------------------
// tme_pkg
// Shared constants, opcodes, error codes and types of the tape machine core.
// ----------------------------------------------------------------------------
package tme_pkg;

	localparam int TAPE_CELLS_DEF    = 32768;
	localparam int PROGRAM_WORDS_DEF = 4096;
	localparam int STACK_ENTRIES_DEF = 64;

	localparam int OP_W   = 4;
	localparam int BYTE_W = 8;
	localparam int ERR_W  = 3;
	localparam int SKIP_W = 7;

	localparam logic [SKIP_W-1:0] SKIP_MAX = 7'd127;

	localparam logic [OP_W-1:0] OP_PTR_INC    = 4'd0;
	localparam logic [OP_W-1:0] OP_PTR_DEC    = 4'd1;
	localparam logic [OP_W-1:0] OP_VAL_INC    = 4'd2;
	localparam logic [OP_W-1:0] OP_VAL_DEC    = 4'd3;
	localparam logic [OP_W-1:0] OP_PRINT      = 4'd4;
	localparam logic [OP_W-1:0] OP_READ       = 4'd5;
	localparam logic [OP_W-1:0] OP_LOOP_BEGIN = 4'd6;
	localparam logic [OP_W-1:0] OP_LOOP_END   = 4'd7;
	localparam logic [OP_W-1:0] OP_DEBUG      = 4'd8;
	localparam logic [OP_W-1:0] OP_END        = 4'd9;

	localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
	localparam logic [ERR_W-1:0] ERR_PTR_OVF   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_PTR_UNF   = 3'd2;
	localparam logic [ERR_W-1:0] ERR_STACK_OVF = 3'd3;
	localparam logic [ERR_W-1:0] ERR_UNMATCHED = 3'd4;

	// index width for a store of n entries, at least one bit
	function automatic int addr_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	typedef struct packed {
		logic issue;
		logic exec;
	} ctrl_t;

endpackage

// ===== hw/rtl/tme_ram.sv =====
// ----------------------------------------------------------------------------
// tme_ram
// Single-port-write, single-port-read synchronous RAM with registered read
// data, write data bypassed to a read of the same address.
// ----------------------------------------------------------------------------
module tme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/tme_exec.sv =====
// ----------------------------------------------------------------------------
// tme_exec
// Execute stage: machine state registers, tape and return stack memories,
// read-modify-write of the current cell and next-state logic.
// ----------------------------------------------------------------------------
module tme_exec import tme_pkg::*; #(
	parameter int TAPE_CELLS    = TAPE_CELLS_DEF,
	parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF,
	parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
	parameter int PTR_W         = addr_w(TAPE_CELLS),
	parameter int PC_W          = addr_w(PROGRAM_WORDS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	input  logic [OP_W-1:0]   op,
	input  logic [BYTE_W-1:0] rd_byte,
	output logic [PC_W-1:0]   res_next_pc,
	output logic              res_print_valid,
	output logic [BYTE_W-1:0] res_print_byte,
	output logic              res_debug_valid,
	output logic [PTR_W-1:0]  res_debug_pointer,
	output logic [BYTE_W-1:0] res_debug_value,
	output logic              res_halted,
	output logic [ERR_W-1:0]  res_error_code
);

	localparam int FILL_W  = $clog2(TAPE_CELLS + 1);
	localparam int SAW     = addr_w(STACK_ENTRIES);
	localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);

	localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(TAPE_CELLS - 1);
	localparam logic [PC_W-1:0]    PC_LAST    = PC_W'(PROGRAM_WORDS - 1);
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_ENTRIES);

	logic [PTR_W-1:0]   dp_q, dp_n, dp_nx;
	logic [PC_W-1:0]    pc_q, pc_n, pc_adv, top_adv;
	logic [DEPTH_W-1:0] depth_q, depth_n, depth_nx;
	logic [SKIP_W-1:0]  skip_q, skip_n;
	logic               stopped_q, stopped_n;
	logic [ERR_W-1:0]   err_q, err_n;
	logic [FILL_W-1:0]  fill_q, fill_n;
	logic               fresh_s2;

	logic               tape_we;
	logic [BYTE_W-1:0]  tape_wd, tape_rdata, cur_byte;
	logic [PTR_W-1:0]   tape_raddr;
	logic               stack_we;
	logic [PC_W-1:0]    stack_rdata;
	logic [SAW-1:0]     stack_raddr;
	logic               at_fill;

	// cells at or above the fill count were never written and read as zero
	assign cur_byte = fresh_s2 ? '0 : tape_rdata;
	assign at_fill  = (FILL_W'(dp_q) == fill_q);
	assign pc_adv   = (pc_q == PC_LAST) ? '0 : pc_q + 1'b1;
	assign top_adv  = (stack_rdata == PC_LAST) ? '0 : stack_rdata + 1'b1;

	always_comb begin
		dp_n            = dp_q;
		pc_n            = pc_adv;
		depth_n         = depth_q;
		skip_n          = skip_q;
		stopped_n       = stopped_q;
		err_n           = err_q;
		tape_we         = 1'b0;
		tape_wd         = cur_byte;
		stack_we        = 1'b0;
		res_print_valid = 1'b0;
		res_print_byte  = '0;
		res_debug_valid = 1'b0;
		res_debug_pointer = '0;
		res_debug_value = '0;
		if (stopped_q) begin
			pc_n = pc_q;
		end else if (skip_q != '0) begin
			case (op)
				OP_END: begin
					stopped_n = 1'b1;
					err_n     = ERR_NONE;
					pc_n      = pc_q;
				end
				OP_LOOP_BEGIN: begin
					if (skip_q >= SKIP_MAX) begin
						stopped_n = 1'b1;
						err_n     = ERR_STACK_OVF;
						pc_n      = pc_q;
					end else begin
						skip_n = skip_q + 1'b1;
					end
				end
				OP_LOOP_END: begin
					skip_n = skip_q - 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			case (op)
				OP_PTR_INC: begin
					if (dp_q >= PTR_LAST) begin
						stopped_n = 1'b1;
						err_n     = ERR_PTR_OVF;
						pc_n      = pc_q;
					end else begin
						dp_n = dp_q + 1'b1;
						// leaving a fresh cell: give it its zero before moving on
						if (at_fill) begin
							tape_we = 1'b1;
							tape_wd = '0;
						end
					end
				end
				OP_PTR_DEC: begin
					if (dp_q == '0) begin
						stopped_n = 1'b1;
						err_n     = ERR_PTR_UNF;
						pc_n      = pc_q;
					end else begin
						dp_n = dp_q - 1'b1;
					end
				end
				OP_VAL_INC: begin
					tape_we = 1'b1;
					tape_wd = cur_byte + 8'd1;
				end
				OP_VAL_DEC: begin
					tape_we = 1'b1;
					tape_wd = cur_byte - 8'd1;
				end
				OP_PRINT: begin
					res_print_valid = 1'b1;
					res_print_byte  = cur_byte;
				end
				OP_READ: begin
					tape_we = 1'b1;
					tape_wd = rd_byte;
				end
				OP_LOOP_BEGIN: begin
					if (cur_byte == '0) begin
						skip_n = SKIP_W'(1);
					end else if (depth_q >= DEPTH_FULL) begin
						stopped_n = 1'b1;
						err_n     = ERR_STACK_OVF;
						pc_n      = pc_q;
					end else begin
						stack_we = 1'b1;
						depth_n  = depth_q + 1'b1;
					end
				end
				OP_LOOP_END: begin
					if (depth_q == '0) begin
						stopped_n = 1'b1;
						err_n     = ERR_UNMATCHED;
						pc_n      = pc_q;
					end else if (cur_byte == '0) begin
						depth_n = depth_q - 1'b1;
					end else begin
						pc_n = top_adv;
					end
				end
				OP_DEBUG: begin
					res_debug_valid   = 1'b1;
					res_debug_pointer = dp_q;
					res_debug_value   = cur_byte;
				end
				OP_END: begin
					stopped_n = 1'b1;
					err_n     = ERR_NONE;
					pc_n      = pc_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign res_next_pc    = pc_n;
	assign res_halted     = stopped_n;
	assign res_error_code = err_n;

	// state seen by an item issued this cycle
	assign dp_nx       = ctrl.exec ? dp_n : dp_q;
	assign depth_nx    = ctrl.exec ? depth_n : depth_q;
	assign fill_n      = (ctrl.exec && tape_we && at_fill) ? fill_q + 1'b1 : fill_q;
	assign tape_raddr  = dp_nx;
	assign stack_raddr = SAW'(depth_nx - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q      <= '0;
			pc_q      <= '0;
			depth_q   <= '0;
			skip_q    <= '0;
			stopped_q <= 1'b0;
			err_q     <= ERR_NONE;
			fill_q    <= '0;
		end else begin
			if (ctrl.exec) begin
				dp_q      <= dp_n;
				pc_q      <= pc_n;
				depth_q   <= depth_n;
				skip_q    <= skip_n;
				stopped_q <= stopped_n;
				err_q     <= err_n;
			end
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			fresh_s2 <= (FILL_W'(tape_raddr) >= fill_n);
		end
	end

	tme_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TAPE_CELLS),
		.AW    (PTR_W)
	) u_tape (
		.clk   (clk),
		.we    (ctrl.exec && tape_we),
		.waddr (dp_q),
		.wdata (tape_wd),
		.re    (ctrl.issue),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	tme_ram #(
		.WIDTH (PC_W),
		.DEPTH (STACK_ENTRIES),
		.AW    (SAW)
	) u_stack (
		.clk   (clk),
		.we    (ctrl.exec && stack_we),
		.waddr (depth_q[SAW-1:0]),
		.wdata (pc_q),
		.re    (ctrl.issue),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	a_stopped_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halt flag cleared");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.exec |=> $stable(dp_q) && $stable(pc_q) && $stable(depth_q))
		else $error("state moved without an executed instruction");

	a_ptr_within_fill: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_W'(dp_q) <= fill_q)
		else $error("data pointer beyond fill count");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |-> stopped_q)
		else $error("error code without halt");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_FULL)
		else $error("return depth out of range");

endmodule

// ===== hw/rtl/tape_machine_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor
// Tape machine core: executes one fetched instruction per transfer.
//
// The input channel (in_valid/in_ready) carries the opcode fetched at the
// address last reported as next_pc (zero after reset) and a byte for reads.
// The output channel (out_valid/out_ready) returns one result per input
// transfer: next fetch address, print and debug values, halt and error code.
// An instruction reads its tape cell and stack top in the cycle it is
// accepted and executes once the output register is empty or being read
// out, its result then loaded into the output register. One instruction
// is taken per cycle while the receiver does not stall, with back-to-back
// read-modify-write on the tape and stack memories served by write bypass.
// After reset the tape reads as all zero through a fill count of cells
// written so far; no clearing pass is run and in_ready rises right away.
// When the receiver stalls, the output register holds its result, the
// execute stage holds one more instruction and in_ready falls.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor import tme_pkg::*; #(
	parameter int TAPE_CELLS    = TAPE_CELLS_DEF,
	parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF,
	parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
	localparam int PTR_W        = addr_w(TAPE_CELLS),
	localparam int PC_W         = addr_w(PROGRAM_WORDS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   opcode,
	input  logic [BYTE_W-1:0] input_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PC_W-1:0]   next_pc,
	output logic              print_valid,
	output logic [BYTE_W-1:0] print_byte,
	output logic              debug_valid,
	output logic [PTR_W-1:0]  debug_pointer,
	output logic [BYTE_W-1:0] debug_value,
	output logic              halted,
	output logic [ERR_W-1:0]  error_code
);

	logic              valid_s2;
	logic [OP_W-1:0]   op_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic              out_valid_q;
	ctrl_t             ctrl;

	logic [PC_W-1:0]   r_next_pc;
	logic              r_print_valid;
	logic [BYTE_W-1:0] r_print_byte;
	logic              r_debug_valid;
	logic [PTR_W-1:0]  r_debug_pointer;
	logic [BYTE_W-1:0] r_debug_value;
	logic              r_halted;
	logic [ERR_W-1:0]  r_error_code;

	logic [PC_W-1:0]   next_pc_q;
	logic              print_valid_q;
	logic [BYTE_W-1:0] print_byte_q;
	logic              debug_valid_q;
	logic [PTR_W-1:0]  debug_pointer_q;
	logic [BYTE_W-1:0] debug_value_q;
	logic              halted_q;
	logic [ERR_W-1:0]  error_code_q;

	assign ctrl.exec  = valid_s2 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s2 || ctrl.exec;
	assign ctrl.issue = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (ctrl.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			op_s2   <= opcode;
			byte_s2 <= input_byte;
		end
		if (ctrl.exec) begin
			next_pc_q       <= r_next_pc;
			print_valid_q   <= r_print_valid;
			print_byte_q    <= r_print_byte;
			debug_valid_q   <= r_debug_valid;
			debug_pointer_q <= r_debug_pointer;
			debug_value_q   <= r_debug_value;
			halted_q        <= r_halted;
			error_code_q    <= r_error_code;
		end
	end

	tme_exec #(
		.TAPE_CELLS    (TAPE_CELLS),
		.PROGRAM_WORDS (PROGRAM_WORDS),
		.STACK_ENTRIES (STACK_ENTRIES),
		.PTR_W         (PTR_W),
		.PC_W          (PC_W)
	) u_exec (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.op                (op_s2),
		.rd_byte           (byte_s2),
		.res_next_pc       (r_next_pc),
		.res_print_valid   (r_print_valid),
		.res_print_byte    (r_print_byte),
		.res_debug_valid   (r_debug_valid),
		.res_debug_pointer (r_debug_pointer),
		.res_debug_value   (r_debug_value),
		.res_halted        (r_halted),
		.res_error_code    (r_error_code)
	);

	assign out_valid     = out_valid_q;
	assign next_pc       = next_pc_q;
	assign print_valid   = print_valid_q;
	assign print_byte    = print_byte_q;
	assign debug_valid   = debug_valid_q;
	assign debug_pointer = debug_pointer_q;
	assign debug_value   = debug_value_q;
	assign halted        = halted_q;
	assign error_code    = error_code_q;

endmodule

// ===== tb/sv/tb_tape_machine_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// tb_tape_machine_instruction_executor
// Self-checking bench for the tape machine core. A short table of directed
// instructions covers wrap of cell arithmetic, reads with end of input,
// nested skipping, taken and falling-through loop ends and a no-op code.
// Random instruction streams follow, steered away from halting, then a walk
// to a program counter wrap, and finally one randomly chosen stop condition
// (end, pointer overflow or underflow, full stack, deep skip nesting,
// unmatched loop end, end while skipping) with a few items after the halt.
// Every result transfer is compared field by field with a table entry or an internal model.
// ----------------------------------------------------------------------------
module tb_tape_machine_instruction_executor import tme_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PC_W = $clog2(PROGRAM_WORDS_DEF);
	localparam int PTR_W = $clog2(TAPE_CELLS_DEF);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(TAPE_CELLS_DEF - 1);
	localparam logic [OP_W-1:0] OP_NOP_FIRST = 4'd10;
	localparam logic [OP_W-1:0] OP_NOP_LAST = 4'd15;
	localparam int RANDOM_ITEMS = 1500;
	localparam int DIR_N = 26;

	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic              print_valid;
		logic [BYTE_W-1:0] print_byte;
		logic              debug_valid;
		logic [PTR_W-1:0]  debug_pointer;
		logic [BYTE_W-1:0] debug_value;
		logic              halted;
		logic [ERR_W-1:0]  error_code;
	} exec_result_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] data;
		logic              typed;
		exec_result_t      want;
	} dir_row_t;

	typedef enum int {
		STOP_BY_END,
		STOP_PTR_OVF,
		STOP_PTR_UNF,
		STOP_STACK_FULL,
		STOP_SKIP_DEEP,
		STOP_UNMATCHED,
		STOP_END_SKIPPING
	} stop_kind_e;

	localparam exec_result_t NO_CHECK = '0;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{OP_DEBUG, 8'h00, 1'b1,
			'{12'd1, 1'b0, 8'd0, 1'b1, 15'd0, 8'd0, 1'b0, ERR_NONE}},
		'{OP_PRINT, 8'h00, 1'b1,
			'{12'd2, 1'b1, 8'd0, 1'b0, 15'd0, 8'd0, 1'b0, ERR_NONE}},
		'{OP_VAL_DEC, 8'h00, 1'b0, NO_CHECK},
		'{OP_PRINT, 8'h00, 1'b1,
			'{12'd4, 1'b1, 8'd255, 1'b0, 15'd0, 8'd0, 1'b0, ERR_NONE}},
		'{OP_VAL_INC, 8'h00, 1'b0, NO_CHECK},
		'{OP_READ, 8'hff, 1'b0, NO_CHECK},
		'{OP_PRINT, 8'h00, 1'b1,
			'{12'd7, 1'b1, 8'd255, 1'b0, 15'd0, 8'd0, 1'b0, ERR_NONE}},
		'{OP_READ, 8'h00, 1'b0, NO_CHECK},
		'{OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK},
		'{OP_VAL_INC, 8'h00, 1'b0, NO_CHECK},
		'{OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK},
		'{OP_DEBUG, 8'h00, 1'b0, NO_CHECK},
		'{OP_PTR_DEC, 8'h00, 1'b0, NO_CHECK},
		'{OP_LOOP_END, 8'h00, 1'b0, NO_CHECK},
		'{OP_LOOP_END, 8'h00, 1'b0, NO_CHECK},
		'{OP_PRINT, 8'h00, 1'b0, NO_CHECK},
		'{OP_PTR_INC, 8'h00, 1'b0, NO_CHECK},
		'{OP_READ, 8'haa, 1'b0, NO_CHECK},
		'{OP_READ, 8'h55, 1'b0, NO_CHECK},
		'{OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK},
		'{OP_LOOP_END, 8'h00, 1'b0, NO_CHECK},
		'{OP_READ, 8'h00, 1'b0, NO_CHECK},
		'{OP_LOOP_END, 8'h00, 1'b0, NO_CHECK},
		'{OP_NOP_LAST, 8'h00, 1'b0, NO_CHECK},
		'{OP_PTR_DEC, 8'h00, 1'b0, NO_CHECK},
		'{OP_DEBUG, 8'h00, 1'b0, NO_CHECK}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [OP_W-1:0]   opcode;
	logic [BYTE_W-1:0] input_byte;
	logic              out_valid;
	logic              out_ready;
	logic [PC_W-1:0]   next_pc;
	logic              print_valid;
	logic [BYTE_W-1:0] print_byte;
	logic              debug_valid;
	logic [PTR_W-1:0]  debug_pointer;
	logic [BYTE_W-1:0] debug_value;
	logic              halted;
	logic [ERR_W-1:0]  error_code;

	// machine image kept by the bench
	logic [BYTE_W-1:0] tape_img [TAPE_CELLS_DEF];
	logic [PC_W-1:0]   ret_img [STACK_ENTRIES_DEF];
	logic [PTR_W-1:0]  ptr_img;
	logic [PC_W-1:0]   pc_img;
	int                depth_img;
	int                skip_img;
	logic              stopped_img;
	logic [ERR_W-1:0]  err_img;

	exec_result_t expected_results [$];
	bit failed;
	bit tx_burst;
	bit rx_burst;

	tape_machine_instruction_executor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.input_byte   (input_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_pc      (next_pc),
		.print_valid  (print_valid),
		.print_byte   (print_byte),
		.debug_valid  (debug_valid),
		.debug_pointer(debug_pointer),
		.debug_value  (debug_value),
		.halted       (halted),
		.error_code   (error_code)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [PC_W-1:0] step_addr(input logic [PC_W-1:0] pc);
		return (pc == PC_W'(PROGRAM_WORDS_DEF - 1)) ? '0 : pc + 1'b1;
	endfunction

	function automatic void stop_machine(input logic [ERR_W-1:0] code);
		stopped_img = 1'b1;
		err_img = code;
	endfunction

	function automatic exec_result_t exec_instr(input logic [OP_W-1:0] op,
			input logic [BYTE_W-1:0] data);
		exec_result_t r;
		logic [PC_W-1:0] pc_now;
		r = '0;
		pc_now = pc_img;
		r.next_pc = step_addr(pc_now);
		if (stopped_img) begin
			r.next_pc = pc_now;
		end else if (skip_img != 0) begin
			if (op == OP_END) begin
				stop_machine(ERR_NONE);
			end else if (op == OP_LOOP_BEGIN) begin
				if (skip_img >= SKIP_MAX) stop_machine(ERR_STACK_OVF);
				else skip_img++;
			end else if (op == OP_LOOP_END) begin
				skip_img--;
			end
		end else begin
			case (op)
				OP_PTR_INC: begin
					if (ptr_img == PTR_MAX) stop_machine(ERR_PTR_OVF);
					else ptr_img++;
				end
				OP_PTR_DEC: begin
					if (ptr_img == '0) stop_machine(ERR_PTR_UNF);
					else ptr_img--;
				end
				OP_VAL_INC: tape_img[ptr_img] = tape_img[ptr_img] + 1'b1;
				OP_VAL_DEC: tape_img[ptr_img] = tape_img[ptr_img] - 1'b1;
				OP_PRINT: begin
					r.print_valid = 1'b1;
					r.print_byte = tape_img[ptr_img];
				end
				OP_READ: tape_img[ptr_img] = data;
				OP_LOOP_BEGIN: begin
					if (tape_img[ptr_img] == '0) begin
						skip_img = 1;
					end else if (depth_img >= STACK_ENTRIES_DEF) begin
						stop_machine(ERR_STACK_OVF);
					end else begin
						ret_img[depth_img] = pc_now;
						depth_img++;
					end
				end
				OP_LOOP_END: begin
					if (depth_img == 0) stop_machine(ERR_UNMATCHED);
					else if (tape_img[ptr_img] == '0) depth_img--;
					else r.next_pc = step_addr(ret_img[depth_img-1]);
				end
				OP_DEBUG: begin
					r.debug_valid = 1'b1;
					r.debug_pointer = ptr_img;
					r.debug_value = tape_img[ptr_img];
				end
				OP_END: stop_machine(ERR_NONE);
				default: ;
			endcase
		end
		// any halt keeps the counter at the stopping address
		if (stopped_img) r.next_pc = pc_now;
		pc_img = r.next_pc;
		r.halted = stopped_img;
		r.error_code = err_img;
		return r;
	endfunction

	// random opcode, steered away from anything that would halt the machine
	function automatic logic [OP_W-1:0] pick_op();
		int unsigned w;
		logic [OP_W-1:0] op;
		w = $urandom_range(0, 99);
		if (w < 12) op = OP_PTR_INC;
		else if (w < 24) op = OP_PTR_DEC;
		else if (w < 38) op = OP_VAL_INC;
		else if (w < 48) op = OP_VAL_DEC;
		else if (w < 56) op = OP_PRINT;
		else if (w < 64) op = OP_READ;
		else if (w < 76) op = OP_LOOP_BEGIN;
		else if (w < 88) op = OP_LOOP_END;
		else if (w < 96) op = OP_DEBUG;
		else op = OP_W'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
		if (skip_img != 0) begin
			if (op == OP_LOOP_BEGIN && (skip_img >= SKIP_MAX || $urandom_range(0, 1) == 0))
				op = OP_LOOP_END;
		end else begin
			if (op == OP_PTR_INC && ptr_img == PTR_MAX) op = OP_PTR_DEC;
			else if (op == OP_PTR_DEC && ptr_img == '0) op = OP_PTR_INC;
			else if (op == OP_LOOP_END && depth_img == 0) op = OP_LOOP_BEGIN;
			if (op == OP_LOOP_BEGIN && depth_img >= STACK_ENTRIES_DEF
					&& tape_img[ptr_img] != '0)
				op = OP_VAL_DEC;
		end
		return op;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	task automatic issue(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
			input logic typed, input exec_result_t want);
		int gap;
		exec_result_t predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		input_byte <= data;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predicted = exec_instr(op, data);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// result side
	initial begin
		int stall;
		exec_result_t w;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 8);
			if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (expected_results.size() == 0) begin
				$error("result transfer with no instruction pending");
				failed = 1'b1;
			end else begin
				w = expected_results.pop_front();
				check_field("next_pc", 32'(w.next_pc), 32'(next_pc));
				check_field("print_valid", 32'(w.print_valid), 32'(print_valid));
				check_field("print_byte", 32'(w.print_byte), 32'(print_byte));
				check_field("debug_valid", 32'(w.debug_valid), 32'(debug_valid));
				check_field("debug_pointer", 32'(w.debug_pointer), 32'(debug_pointer));
				check_field("debug_value", 32'(w.debug_value), 32'(debug_value));
				check_field("halted", 32'(w.halted), 32'(halted));
				check_field("error_code", 32'(w.error_code), 32'(error_code));
			end
		end
	end

	initial begin
		stop_kind_e stop_kind;
		logic [OP_W-1:0] op;
		logic [BYTE_W-1:0] data;
		foreach (tape_img[i]) tape_img[i] = '0;
		foreach (ret_img[i]) ret_img[i] = '0;
		ptr_img = '0;
		pc_img = '0;
		depth_img = 0;
		skip_img = 0;
		stopped_img = 1'b0;
		err_img = ERR_NONE;
		failed = 1'b0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_PTR_INC;
		input_byte = '0;
		out_ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[i])
			issue(DIR_ROWS[i].op, DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		// hold off until the pipeline has drained
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);

		repeat (RANDOM_ITEMS) begin
			op = pick_op();
			data = ($urandom_range(0, 3) == 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
			issue(op, data, 1'b0, NO_CHECK);
		end

		// run the program counter through its wrap
		do begin
			case ($urandom_range(0, 3))
				0: op = OP_VAL_INC;
				1: op = OP_PRINT;
				2: op = OP_DEBUG;
				default: op = OP_W'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
			endcase
			issue(op, BYTE_W'($urandom_range(0, 255)), 1'b0, NO_CHECK);
		end while (pc_img != '0);

		stop_kind = stop_kind_e'($urandom_range(0, STOP_END_SKIPPING));
		if (stop_kind == STOP_END_SKIPPING) begin
			if (skip_img == 0) begin
				issue(OP_READ, 8'h00, 1'b0, NO_CHECK);
				issue(OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK);
			end
		end else begin
			while (skip_img != 0) issue(OP_LOOP_END, 8'h00, 1'b0, NO_CHECK);
		end
		case (stop_kind)
			STOP_PTR_OVF: begin
				while (ptr_img != PTR_MAX) issue(OP_PTR_INC, 8'h00, 1'b0, NO_CHECK);
				issue(OP_PTR_INC, 8'h00, 1'b0, NO_CHECK);
			end
			STOP_PTR_UNF: begin
				while (ptr_img != '0) issue(OP_PTR_DEC, 8'h00, 1'b0, NO_CHECK);
				issue(OP_PTR_DEC, 8'h00, 1'b0, NO_CHECK);
			end
			STOP_STACK_FULL: begin
				if (tape_img[ptr_img] == '0) issue(OP_VAL_INC, 8'h00, 1'b0, NO_CHECK);
				while (depth_img < STACK_ENTRIES_DEF)
					issue(OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK);
				issue(OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK);
			end
			STOP_SKIP_DEEP: begin
				issue(OP_READ, 8'h00, 1'b0, NO_CHECK);
				issue(OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK);
				while (skip_img < SKIP_MAX) issue(OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK);
				issue(OP_LOOP_BEGIN, 8'h00, 1'b0, NO_CHECK);
			end
			STOP_UNMATCHED: begin
				issue(OP_READ, 8'h00, 1'b0, NO_CHECK);
				while (depth_img != 0) issue(OP_LOOP_END, 8'h00, 1'b0, NO_CHECK);
				issue(OP_LOOP_END, 8'h00, 1'b0, NO_CHECK);
			end
			default: issue(OP_END, 8'h00, 1'b0, NO_CHECK);
		endcase

		// a halted machine must ignore everything that follows
		repeat (8) issue(OP_W'($urandom_range(0, OP_NOP_LAST)),
			BYTE_W'($urandom_range(0, 255)), 1'b0, NO_CHECK);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (!failed) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
